@@ rtl/core/ilte_pkg.sv @@
// Shared types and constants of the indexed list table engine.
package ilte_pkg;

   localparam int MODE_BITS       = 3;
   localparam int POS_BITS        = 6;
   localparam int VALUE_BITS      = 32;
   localparam int LENGTH_BITS     = 7;
   localparam int REQ_TDATA_BITS  = 40;
   localparam int RSP_TDATA_BITS  = 48;
   localparam int CMD_QUEUE_DEPTH = 2;

   // Operation codes as carried on the request tuser field.
   typedef enum logic [MODE_BITS-1:0] {
      OP_APPEND    = 3'd0,
      OP_READ      = 3'd1,
      OP_OVERWRITE = 3'd2,
      OP_INSERT    = 3'd3,
      OP_REMOVE    = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_CLEAR     = 3'd6,
      OP_UNUSED    = 3'd7
   } op_type;

   // Classified command handed from the front end to the execution unit.
   typedef struct packed {
      op_type                op;
      logic [POS_BITS-1:0]   position;
      logic                  elem_null;
   } cmd_type;

endpackage

@@ rtl/core/ilte_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module ilte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ilte_cmd_fifo.sv @@
// Short command queue between the front end and the execution unit.
module ilte_cmd_fifo
   import ilte_pkg::*;
#(
   parameter int WIDTH = 42
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(CMD_QUEUE_DEPTH);
   localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [CMD_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CW'(CMD_QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/ilte_front.sv @@
// Request front end: accepts transfers and classifies them into commands.
module ilte_front
   import ilte_pkg::*;
#(
   parameter int ELEMENT_BITS = 32
) (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [MODE_BITS-1:0]      req_tuser,
   input  logic                      queue_full,
   output logic                      push,
   output cmd_type                   cmd,
   output logic [ELEMENT_BITS-1:0]   cmd_elem
);

   logic [VALUE_BITS-1:0]              element;
   logic [ELEMENT_BITS+VALUE_BITS-1:0] element_wide;

   assign element      = req_tdata[POS_BITS +: VALUE_BITS];
   // The element word is cut or zero-extended to the storage width.
   assign element_wide = {{ELEMENT_BITS{1'b0}}, element};
   assign cmd_elem     = element_wide[ELEMENT_BITS-1:0];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      cmd.op        = op_type'(req_tuser);
      cmd.position  = req_tdata[POS_BITS-1:0];
      cmd.elem_null = (cmd_elem == '0);
   end

endmodule

@@ rtl/core/ilte_back.sv @@
// Execution unit: list store, element count, shift and search sequencer.
module ilte_back
   import ilte_pkg::*;
#(
   parameter int CAPACITY     = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   input  logic [ELEMENT_BITS-1:0] cmd_elem,
   output logic                    cmd_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = CW + 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_INSERT,
      ST_INSERT_FIN,
      ST_REMOVE,
      ST_SEARCH
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [ELEMENT_BITS-1:0] elem_ff, elem_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic                    pend_ff, pend_in;
   logic                    cap_ff, cap_in;
   logic [VALUE_BITS-1:0]   hold_ff, hold_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    status_ff, status_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic                    found_ff, found_in;
   logic [POS_BITS-1:0]     fpos_ff, fpos_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic                    empty_ff, empty_in;

   logic                    wr_en, rd_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [ELEMENT_BITS-1:0] wr_data, rd_data;

   logic                    go, fin;
   logic                    res_status, res_found;
   logic [VALUE_BITS-1:0]   res_value;
   logic [POS_BITS-1:0]     res_fpos;

   logic [CMP_W-1:0]        cmd_pos_x, pos_x, count_x, idx_x, cap_x;
   logic [CW-1:0]           cmd_pos_c, idx_dec;
   logic [ELEMENT_BITS+VALUE_BITS-1:0] rd_wide;
   logic [VALUE_BITS-1:0]   rd_value;
   logic [AW+POS_BITS-1:0]  addr_wide;
   logic [CW+LENGTH_BITS-1:0] count_wide;

   ilte_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmd_pos_x = {{(CW+1){1'b0}}, cmd.position};
   assign pos_x     = {{(CW+1){1'b0}}, pos_ff};
   assign count_x   = {7'b0, count_ff};
   assign idx_x     = {7'b0, idx_ff};
   assign cap_x     = CMP_W'(CAPACITY);
   assign cmd_pos_c = cmd_pos_x[CW-1:0];
   assign idx_dec   = idx_ff - 1'b1;
   assign rd_wide   = {{VALUE_BITS{1'b0}}, rd_data};
   assign rd_value  = rd_wide[VALUE_BITS-1:0];
   assign addr_wide = {{POS_BITS{1'b0}}, addr_ff};

   // An item starts only when the result register is free, so the
   // result slot stays free until the item finishes.
   assign go      = (state_ff == ST_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_pop = go;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      elem_in    = elem_ff;
      addr_in    = addr_ff;
      pend_in    = pend_ff;
      cap_in     = cap_ff;
      hold_in    = hold_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = elem_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      fin        = 1'b0;
      res_status = 1'b1;
      res_value  = '0;
      res_found  = 1'b0;
      res_fpos   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               pos_in  = cmd.position;
               elem_in = cmd_elem;
               pend_in = 1'b0;
               cap_in  = 1'b0;
               case (cmd.op)
                  OP_APPEND: begin
                     fin = 1'b1;
                     if (!cmd.elem_null && count_x < cap_x) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[AW-1:0];
                        wr_data    = cmd_elem;
                        count_in   = count_ff + 1'b1;
                        res_status = 1'b0;
                     end
                  end
                  OP_READ: begin
                     if (cmd_pos_x < count_x) begin
                        rd_en    = 1'b1;
                        rd_addr  = cmd_pos_x[AW-1:0];
                        state_in = ST_READ;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  OP_OVERWRITE: begin
                     fin = 1'b1;
                     if (!cmd.elem_null && cmd_pos_x < count_x) begin
                        wr_en      = 1'b1;
                        wr_addr    = cmd_pos_x[AW-1:0];
                        wr_data    = cmd_elem;
                        res_status = 1'b0;
                     end
                  end
                  OP_INSERT: begin
                     if (!cmd.elem_null && cmd_pos_x <= count_x && count_x < cap_x) begin
                        idx_in   = count_ff;
                        state_in = ST_INSERT;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (cmd_pos_x < count_x) begin
                        rd_en    = 1'b1;
                        rd_addr  = cmd_pos_x[AW-1:0];
                        idx_in   = cmd_pos_c + 1'b1;
                        cap_in   = 1'b1;
                        state_in = ST_REMOVE;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (cmd.elem_null) begin
                        fin = 1'b1;
                     end else if (count_ff == '0) begin
                        fin        = 1'b1;
                        res_status = 1'b0;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     fin        = 1'b1;
                     count_in   = '0;
                     res_status = 1'b0;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            fin        = 1'b1;
            res_status = 1'b0;
            res_value  = rd_value;
            state_in   = ST_IDLE;
         end

         // Shift up from the top: read entry idx-1, write it to idx in the next cycle.
         ST_INSERT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = addr_ff;
               wr_data = rd_data;
            end
            if (idx_x > pos_x) begin
               rd_en   = 1'b1;
               rd_addr = idx_dec[AW-1:0];
               addr_in = idx_ff[AW-1:0];
               idx_in  = idx_dec;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_INSERT_FIN;
            end
         end

         ST_INSERT_FIN: begin
            wr_en      = 1'b1;
            wr_addr    = pos_x[AW-1:0];
            wr_data    = elem_ff;
            count_in   = count_ff + 1'b1;
            fin        = 1'b1;
            res_status = 1'b0;
            state_in   = ST_IDLE;
         end

         // Shift down: the first read returns the removed entry, later
         // reads of entry idx are written back to idx-1.
         ST_REMOVE: begin
            cap_in = 1'b0;
            if (cap_ff) begin
               hold_in = rd_value;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = addr_ff;
               wr_data = rd_data;
            end
            if (idx_x < count_x) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               addr_in = idx_dec[AW-1:0];
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in    = 1'b0;
               count_in   = count_ff - 1'b1;
               fin        = 1'b1;
               res_status = 1'b0;
               res_value  = cap_ff ? rd_value : hold_ff;
               state_in   = ST_IDLE;
            end
         end

         // Linear scan from the bottom; the first hit ends the walk.
         ST_SEARCH: begin
            if (pend_ff && rd_data == elem_ff) begin
               pend_in    = 1'b0;
               fin        = 1'b1;
               res_status = 1'b0;
               res_found  = 1'b1;
               res_fpos   = addr_wide[POS_BITS-1:0];
               state_in   = ST_IDLE;
            end else if (idx_x < count_x) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               addr_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in    = 1'b0;
               fin        = 1'b1;
               res_status = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_wide = {{LENGTH_BITS{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;
      length_in    = length_ff;
      empty_in     = empty_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
         status_in    = res_status;
         value_in     = res_value;
         found_in     = res_found;
         fpos_in      = res_fpos;
         length_in    = count_wide[LENGTH_BITS-1:0];
         empty_in     = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      elem_ff   <= elem_in;
      addr_ff   <= addr_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      length_ff <= length_in;
      empty_ff  <= empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {empty_ff, length_ff, fpos_ff, found_ff, value_ff, status_ff};

endmodule

@@ rtl/core/indexed_list_table_engine.sv @@
// Append, overwrite, clear and errors finish in the execution unit's idle state; a read
// adds a registered store read; insert and remove at position p of n walk the entries
// from p to the end of the list, and search walks up to n entries. One item is carried
// out at a time, and each walk is bounded by the single read and write store ports.
// Reset (synchronous, active high) empties the list and the queue; the store keeps its
// contents, which are never read beyond the current length, so no clearing pass is run.
module indexed_list_table_engine
   import ilte_pkg::*;
#(
   parameter int CAPACITY     = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // tdata from bit 0: position[5:0], element[37:6], zero padding[39:38].
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // tuser from bit 0: mode[2:0].
   input  logic [MODE_BITS-1:0]      req_tuser,
   // Result channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // tdata from bit 0: status[0], value[32:1], found[33], found_position[39:34],
   // length[46:40], empty_res[47].
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   // The queue entry packs the element word above the classified command.
   localparam int QW = $bits(cmd_type) + ELEMENT_BITS;

   logic                    push, queue_full, queue_empty, cmd_pop;
   cmd_type                 front_cmd, back_cmd;
   logic [ELEMENT_BITS-1:0] front_elem, back_elem;
   logic [QW-1:0]           queue_in, queue_out;

   // The front end decodes the mode and checks for a null element as the
   // transfer is taken, so the execution unit sees a ready-made command.
   ilte_front #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd),
      .cmd_elem   (front_elem)
   );

   assign queue_in = {front_elem, front_cmd};

   // A short queue lets the request side keep taking transfers while the
   // execution unit walks the store or waits for the result to be taken.
   ilte_cmd_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (queue_in),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   assign back_cmd  = cmd_type'(queue_out[$bits(cmd_type)-1:0]);
   assign back_elem = queue_out[QW-1 -: ELEMENT_BITS];

   // The execution unit owns the list store and the element count, runs the
   // shift and search walks one item at a time and registers the result.
   ilte_back #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd        (back_cmd),
      .cmd_elem   (back_elem),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/sv/tb_indexed_list_table_engine.sv @@
// Self-checking testbench for the indexed list table engine with a scoreboard of list results.
`timescale 1ns / 1ps

module tb_indexed_list_table_engine;
   import ilte_pkg::*;

   // The list has 64 slots of 32-bit element words, matching the block's defaults.
   localparam int LIST_SLOTS  = 64;
   localparam int DRAIN_WAIT  = LIST_SLOTS + 16;
   localparam int REPORT_MAX  = 10;

   // One result as the list engine reports it. The fields are listed from the lowest
   // bit of the result tdata upwards, so the struct itself is not used for packing.
   typedef struct packed {
      logic                   status;
      logic [VALUE_BITS-1:0]  value;
      logic                   found;
      logic [POS_BITS-1:0]    found_position;
      logic [LENGTH_BITS-1:0] length;
      logic                   empty_res;
   } list_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // tdata from bit 0: position[5:0], element[37:6], zero padding[39:38].
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   // tuser from bit 0: mode[2:0].
   logic [MODE_BITS-1:0]      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // tdata from bit 0: status[0], value[32:1], found[33], found_position[39:34],
   // length[46:40], empty_res[47].
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // Our own copy of the list, advanced once for every request transfer.
   logic [VALUE_BITS-1:0] list_words [LIST_SLOTS];
   int                    list_length;

   // Results still owed by the block, oldest first.
   list_result_type pending_results [$];

   int mismatch_count;
   int results_seen;

   // Sender pacing: bursts of back-to-back requests separated by idle gaps.
   bit sender_gaps;
   int burst_left;

   // Receiver controls. A non-zero hold count makes the receiver refuse results until the
   // count runs out; the quiet flag otherwise keeps it ready throughout.
   int hold_left;
   bit rx_always_ready;

   indexed_list_table_engine #(
      .CAPACITY     (LIST_SLOTS),
      .ELEMENT_BITS (VALUE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A generous ceiling: the slowest legal run needs well under a fifth of this.
   initial begin
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // List predictor. Applies one operation to the local copy of the list and
   // returns the result the block must produce for it.
   // ------------------------------------------------------------------------
   function automatic list_result_type apply_list_op(input op_type op,
                                                     input logic [POS_BITS-1:0] pos,
                                                     input logic [VALUE_BITS-1:0] elem);
      list_result_type res;
      int              n;
      res        = '0;
      res.status = 1'b1;
      n          = list_length;
      case (op)
         OP_APPEND: begin
            if (elem != '0 && n < LIST_SLOTS) begin
               list_words[POS_BITS'(n)] = elem;
               list_length              = n + 1;
               res.status               = 1'b0;
            end
         end
         OP_READ: begin
            if (pos < n) begin
               res.value  = list_words[pos];
               res.status = 1'b0;
            end
         end
         OP_OVERWRITE: begin
            if (elem != '0 && pos < n) begin
               list_words[pos] = elem;
               res.status      = 1'b0;
            end
         end
         OP_INSERT: begin
            // Position equal to the length is a legal insert and behaves as an append.
            if (elem != '0 && pos <= n && n < LIST_SLOTS) begin
               for (int i = n; i > pos; i--)
                  list_words[POS_BITS'(i)] = list_words[POS_BITS'(i-1)];
               list_words[pos] = elem;
               list_length     = n + 1;
               res.status      = 1'b0;
            end
         end
         OP_REMOVE: begin
            if (pos < n) begin
               res.value = list_words[pos];
               for (int i = pos; i + 1 < n; i++)
                  list_words[POS_BITS'(i)] = list_words[POS_BITS'(i+1)];
               list_length = n - 1;
               res.status  = 1'b0;
            end
         end
         OP_SEARCH: begin
            // The first matching position wins; an empty list simply reports not found.
            if (elem != '0) begin
               res.status = 1'b0;
               for (int i = 0; i < n; i++) begin
                  if (!res.found && list_words[POS_BITS'(i)] == elem) begin
                     res.found          = 1'b1;
                     res.found_position = i[POS_BITS-1:0];
                  end
               end
            end
         end
         OP_CLEAR: begin
            list_length = 0;
            res.status  = 1'b0;
         end
         default: ;
      endcase
      res.length    = list_length[LENGTH_BITS-1:0];
      res.empty_res = (list_length == 0);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; a transfer is seen at the
   // rising edge where valid and ready are both high.
   // ------------------------------------------------------------------------
   task automatic sender_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic send_item(input op_type op, input logic [POS_BITS-1:0] pos,
                            input logic [VALUE_BITS-1:0] elem);
      if (sender_gaps) begin
         if (burst_left == 0) begin
            // Mostly short gaps, now and then a long one.
            if ($urandom_range(0, 3) == 0)
               sender_idle($urandom_range(10, 40));
            else
               sender_idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, elem, pos};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(apply_list_op(op, pos, elem));
   endtask

   // Stop offering requests and wait until every owed result has arrived.
   task automatic wait_drained();
      sender_idle(1);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side. The receiver cycles through styles of its own: always ready,
   // coin-toss ready, mostly stalled, and long alternating runs.
   // ------------------------------------------------------------------------
   initial begin : result_receiver
      int rx_style;
      int rx_phase_left;
      int rx_run_left;
      bit rx_run_ready;
      rx_style      = 0;
      rx_phase_left = 0;
      rx_run_left   = 0;
      rx_run_ready  = 1'b1;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_phase_left == 0) begin
            rx_style      = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 120);
         end
         rx_phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_always_ready || rx_style == 0) begin
            rsp_tready <= 1'b1;
         end else if (rx_style == 1) begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end else if (rx_style == 2) begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end else begin
            if (rx_run_left == 0) begin
               rx_run_ready = !rx_run_ready;
               rx_run_left  = $urandom_range(1, 15);
            end
            rx_run_left--;
            rsp_tready <= rx_run_ready;
         end
      end
   end

   task automatic note_mismatch(input string what, input logic [VALUE_BITS-1:0] want,
                                input logic [VALUE_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t: result %0d %s mismatch: expected %0h, got %0h",
                  $realtime, results_seen, what, want, got);
   endtask

   // Every result transfer is compared field by field with the oldest prediction.
   always @(posedge clock) begin : result_check
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status         = rsp_tdata[0];
         got.value          = rsp_tdata[32:1];
         got.found          = rsp_tdata[33];
         got.found_position = rsp_tdata[39:34];
         got.length         = rsp_tdata[46:40];
         got.empty_res      = rsp_tdata[47];
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected", '0, rsp_tdata[31:0]);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               note_mismatch("status", VALUE_BITS'(want.status), VALUE_BITS'(got.status));
            if (got.value !== want.value)
               note_mismatch("value", want.value, got.value);
            if (got.found !== want.found)
               note_mismatch("found", VALUE_BITS'(want.found), VALUE_BITS'(got.found));
            if (got.found_position !== want.found_position)
               note_mismatch("found_position", VALUE_BITS'(want.found_position),
                             VALUE_BITS'(got.found_position));
            if (got.length !== want.length)
               note_mismatch("length", VALUE_BITS'(want.length), VALUE_BITS'(got.length));
            if (got.empty_res !== want.empty_res)
               note_mismatch("empty_res", VALUE_BITS'(want.empty_res),
                             VALUE_BITS'(got.empty_res));
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // Random choices for the traffic phases.
   // ------------------------------------------------------------------------
   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      // Lean towards removal near the top and towards growth near the bottom so that
      // the length wanders over the whole range.
      if (list_length >= 56 && r < 40)
         return OP_REMOVE;
      if (list_length <= 4 && r < 30)
         return OP_APPEND;
      if (r < 20) return OP_APPEND;
      if (r < 30) return OP_READ;
      if (r < 40) return OP_OVERWRITE;
      if (r < 58) return OP_INSERT;
      if (r < 74) return OP_REMOVE;
      if (r < 93) return OP_SEARCH;
      if (r < 94) return OP_CLEAR;
      if (r < 96) return OP_UNUSED;
      return OP_APPEND;
   endfunction

   // Small values repeat often so that searches hit and duplicates appear; a few
   // nulls and fully random words cover the error path and every bit.
   function automatic logic [VALUE_BITS-1:0] pick_element();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      if (r < 50)
         return $urandom_range(1, 12);
      if (r < 62 && list_length > 0)
         return list_words[POS_BITS'($urandom_range(0, list_length - 1))];
      return $urandom;
   endfunction

   function automatic logic [POS_BITS-1:0] pick_position();
      if (list_length > 0 && $urandom_range(0, 99) < 85)
         return POS_BITS'($urandom_range(0, list_length));
      return POS_BITS'($urandom_range(0, LIST_SLOTS - 1));
   endfunction

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Extremes of each field, every operation and each special case on a short list.
   task automatic test_directed_cases();
      send_item(OP_CLEAR,     6'd0,  32'd0);             // clear of an empty list
      send_item(OP_SEARCH,    6'd0,  32'd5);             // search of an empty list
      send_item(OP_READ,      6'd0,  32'd0);             // read beyond the length
      send_item(OP_REMOVE,    6'd0,  32'd0);             // remove from an empty list
      send_item(OP_APPEND,    6'd0,  32'd0);             // null element refused
      send_item(OP_APPEND,    6'd63, 32'hFFFF_FFFF);
      send_item(OP_APPEND,    6'd0,  32'd1);
      send_item(OP_INSERT,    6'd0,  32'hA5A5_A5A5);     // insert at the head
      send_item(OP_INSERT,    6'd3,  32'h5A5A_5A5A);     // insert at the length
      send_item(OP_INSERT,    6'd5,  32'd7);             // insert past the length
      send_item(OP_INSERT,    6'd1,  32'd0);             // null insert refused
      send_item(OP_OVERWRITE, 6'd1,  32'h8000_0000);
      send_item(OP_OVERWRITE, 6'd4,  32'd9);             // overwrite at the length
      send_item(OP_OVERWRITE, 6'd0,  32'd0);             // null overwrite refused
      send_item(OP_READ,      6'd3,  32'hFFFF_FFFF);
      send_item(OP_READ,      6'd63, 32'd0);
      send_item(OP_APPEND,    6'd0,  32'd1);             // duplicate of an earlier entry
      send_item(OP_SEARCH,    6'd0,  32'd1);             // first match must be reported
      send_item(OP_SEARCH,    6'd0,  32'd0);             // null search refused
      send_item(OP_SEARCH,    6'd63, 32'h1234_5678);     // absent element
      send_item(OP_REMOVE,    6'd0,  32'd0);
      send_item(OP_REMOVE,    6'd63, 32'd0);             // remove past the length
      send_item(OP_UNUSED,    6'd2,  32'd3);             // unused mode is an error
      send_item(OP_CLEAR,     6'd17, 32'hDEAD_BEEF);
      wait_drained();
   endtask

   // Fill every slot, then exercise the full-store refusals and the longest shifts.
   task automatic test_full_store();
      logic [VALUE_BITS-1:0] word;
      send_item(OP_CLEAR, 6'd0, 32'd0);
      while (list_length < LIST_SLOTS) begin
         word = $urandom;
         if (word == '0)
            word = 32'd1;
         send_item(OP_APPEND, POS_BITS'($urandom_range(0, LIST_SLOTS - 1)), word);
      end
      send_item(OP_APPEND,    6'd0,  32'd42);
      send_item(OP_INSERT,    6'd0,  32'd42);
      send_item(OP_SEARCH,    6'd0,  list_words[LIST_SLOTS-1]);
      send_item(OP_READ,      6'd63, 32'd0);
      send_item(OP_OVERWRITE, 6'd63, 32'hFFFF_FFFF);
      send_item(OP_REMOVE,    6'd0,  32'd0);
      send_item(OP_INSERT,    6'd0,  32'h0000_0001);
      send_item(OP_REMOVE,    6'd63, 32'd0);
      send_item(OP_INSERT,    6'd63, 32'h7FFF_FFFF);
      send_item(OP_CLEAR,     6'd0,  32'd0);
      wait_drained();
   endtask

   // The receiver refuses results for a long stretch while requests keep coming, so
   // the block's queue fills and it must hold its request ready low.
   task automatic test_back_pressure();
      sender_gaps = 1'b0;
      hold_left   = 300;
      repeat (14)
         send_item(pick_op(), pick_position(), pick_element());
      wait_drained();
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_traffic(input int count, input bit quiet);
      sender_gaps     = !quiet;
      rx_always_ready = quiet;
      repeat (count)
         send_item(pick_op(), pick_position(), pick_element());
      wait_drained();
      sender_gaps     = 1'b1;
      rx_always_ready = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = OP_APPEND;
      list_length     = 0;
      mismatch_count  = 0;
      results_seen    = 0;
      sender_gaps     = 1'b1;
      burst_left      = 0;
      hold_left       = 0;
      rx_always_ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_store();
      test_back_pressure();
      test_random_traffic(300, 1'b0);
      test_random_traffic(300, 1'b0);
      test_random_traffic(200, 1'b1);
      test_random_traffic(400, 1'b0);

      // Let any stray result surface before judging the run.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
